### src/mfb_pkg.sv
// Shared types and constants for the monochrome framebuffer raster unit.
`default_nettype none
package mfb_pkg;
    localparam int COLUMNS_DEF = 128;
    localparam int ROWS_DEF = 64;

    typedef enum logic [2:0] {
        KIND_DOT    = 3'd0,
        KIND_TOGGLE = 3'd1,
        KIND_LINE   = 3'd2,
        KIND_CIRCLE = 3'd3,
        KIND_READ   = 3'd4,
        KIND_CLEAR  = 3'd5,
        KIND_RSV0   = 3'd6,
        KIND_RSV1   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        MODE_CLR = 2'd0,
        MODE_SET = 2'd1,
        MODE_XOR = 2'd2
    } mode_t;

    // Classified command handed from the front end to the draw engine.
    typedef struct packed {
        logic [2:0] kind;
        logic       bad;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] ex;
        logic [7:0] ey;
        logic [7:0] r;
        logic       on;
    } cmd_t;
endpackage
`default_nettype wire

### src/mono_framebuffer_line_circle_raster_unit.sv
// Top level of the monochrome framebuffer line and circle raster unit.
`default_nettype none
// Command words queue in a two-entry buffer ahead of a draw engine that owns
// the framebuffer memory. Each plotted dot is a read-modify-write of one store
// byte, latched, read and then written back; a circle plots eight points per
// step of its octant walk. The clear command zeroes the store one byte per
// cycle. After reset the engine runs the same sweep before it takes the first
// word; the queue accepts up to two words meanwhile. A stalled result holds the
// engine.
module mono_framebuffer_line_circle_raster_unit #(
    parameter int COLUMNS = mfb_pkg::COLUMNS_DEF,
    parameter int ROWS    = mfb_pkg::ROWS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  wire [2:0]  kind,
    input  wire [7:0]  start_x,
    input  wire [7:0]  start_y,
    input  wire [7:0]  end_x,
    input  wire [7:0]  end_y,
    input  wire [7:0]  radius,
    input  wire        pixel_on,
    output logic       out_valid,
    input  wire        out_stall,
    output logic [7:0] read_byte,
    output logic       bad_command
);
    import mfb_pkg::*;

    logic q_valid, q_take;
    cmd_t q_cmd;

    mfb_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .start_x(start_x), .start_y(start_y), .end_x(end_x),
        .end_y(end_y), .radius(radius), .pixel_on(pixel_on),
        .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
    );

    mfb_engine #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_engine (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_cmd(q_cmd), .out_valid(out_valid), .out_stall(out_stall),
        .read_byte(read_byte), .bad_command(bad_command)
    );

    a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("queue popped while empty");
    a_no_bad_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_command) |-> (read_byte == 8'd0))
        else $error("invalid command returned data");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_byte)))
        else $error("stalled result changed");
endmodule
`default_nettype wire

### src/mfb_front.sv
// Command front end: accepts input words and queues them for the draw engine.
`default_nettype none
module mfb_front (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    input  wire [2:0]        kind,
    input  wire [7:0]        start_x,
    input  wire [7:0]        start_y,
    input  wire [7:0]        end_x,
    input  wire [7:0]        end_y,
    input  wire [7:0]        radius,
    input  wire              pixel_on,
    output logic             q_valid,
    input  wire              q_take,
    output mfb_pkg::cmd_t    q_cmd
);
    import mfb_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic       push;
    cmd_t       c;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = slot_reg[rd_reg];

    always_comb
    begin
        c.kind = kind;
        c.bad  = (kind == KIND_RSV0) || (kind == KIND_RSV1);
        c.sx   = start_x;
        c.sy   = start_y;
        c.ex   = end_x;
        c.ey   = end_y;
        c.r    = radius;
        c.on   = pixel_on;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (q_take)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_take};
        end
    end
endmodule
`default_nettype wire

### src/mfb_engine.sv
// Draw engine: dot, toggle, line and circle rasterizing, byte reads and clears on the page-organized store.
`default_nettype none
module mfb_engine #(
    parameter int COLUMNS = mfb_pkg::COLUMNS_DEF,
    parameter int ROWS    = mfb_pkg::ROWS_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              q_valid,
    output logic             q_take,
    input  mfb_pkg::cmd_t    q_cmd,
    output logic             out_valid,
    input  wire              out_stall,
    output logic [7:0]       read_byte,
    output logic             bad_command
);
    import mfb_pkg::*;

    localparam int PAGES = (ROWS + 7) / 8;
    localparam int DEPTH = PAGES * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    // Reciprocals for exact modulo of 8-bit values by the frame sizes.
    localparam logic [16:0] RCP_C = 17'((65536 + COLUMNS - 1) / COLUMNS);
    localparam logic [16:0] RCP_R = 17'((65536 + ROWS - 1) / ROWS);
    localparam logic [16:0] RCP_P = 17'((65536 + PAGES - 1) / PAGES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_GEN   = 9'b000000100,
        S_RD    = 9'b000001000,
        S_WR    = 9'b000010000,
        S_RDB   = 9'b000100000,
        S_RDB2  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_START = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // The store is zeroed by a sweep of one byte per cycle, after reset and on clear.
    logic [7:0]    mem [DEPTH];
    logic          boot_reg;
    logic [AW-1:0] clr_reg;
    logic [7:0]    rdata_reg;

    cmd_t          cmd_reg;
    mode_t         mode_reg;
    logic [7:0]    col_reg, row_reg, stx_reg, sty_reg;
    logic [8:0]    dx_reg, dy_reg, dist_reg, xe_reg, ye_reg;
    logic [8:0]    t_reg;
    logic [7:0]    cx_reg;
    logic signed [8:0] cy_reg;
    logic signed [11:0] d_reg;
    logic [2:0]    oct_reg;
    logic [7:0]    px_reg, py_reg;
    logic [7:0]    obyte_reg;
    logic          obad_reg;

    logic [AW-1:0] addr_reg;
    logic [7:0]    bit_reg;

    logic [7:0]    ox, oy;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    wbit;
    logic [7:0]    cur;
    logic [7:0]    newb;
    logic [8:0]    xe_n, ye_n;
    logic          clr_last;
    logic          gen_done;

    function automatic logic [7:0] mod_by(input logic [7:0] v, input logic [16:0] rcp,
                                          input logic [8:0] m);
        logic [24:0] prod;
        logic [17:0] back;
        prod = {17'd0, v} * {8'd0, rcp};
        back = {9'd0, prod[24:16]} * {9'd0, m};
        return v - back[7:0];
    endfunction

    assign q_take      = (state_reg == S_IDLE) && q_valid;
    assign out_valid   = (state_reg == S_OUT);
    assign read_byte   = obyte_reg;
    assign bad_command = obad_reg;
    assign cur         = rdata_reg;
    assign clr_last    = (clr_reg == AW'(DEPTH - 1));

    // Octant point for the current circle step.
    always_comb
    begin
        case (oct_reg)
            3'd0: begin ox = cmd_reg.sx + cx_reg; oy = cmd_reg.sy + cy_reg[7:0]; end
            3'd1: begin ox = cmd_reg.sx - cx_reg; oy = cmd_reg.sy + cy_reg[7:0]; end
            3'd2: begin ox = cmd_reg.sx + cx_reg; oy = cmd_reg.sy - cy_reg[7:0]; end
            3'd3: begin ox = cmd_reg.sx - cx_reg; oy = cmd_reg.sy - cy_reg[7:0]; end
            3'd4: begin ox = cmd_reg.sx + cy_reg[7:0]; oy = cmd_reg.sy + cx_reg; end
            3'd5: begin ox = cmd_reg.sx - cy_reg[7:0]; oy = cmd_reg.sy + cx_reg; end
            3'd6: begin ox = cmd_reg.sx + cy_reg[7:0]; oy = cmd_reg.sy - cx_reg; end
            default: begin ox = cmd_reg.sx - cy_reg[7:0]; oy = cmd_reg.sy - cx_reg; end
        endcase
    end

    // The plot point is already wrapped to the frame when it is latched.
    always_comb
    begin
        waddr = AW'((32'(py_reg) >> 3) * COLUMNS + 32'(px_reg));
        wbit  = 8'(1) << py_reg[2:0];
        raddr = (state_reg == S_RDB) ? addr_reg : waddr;
    end

    always_comb
    begin
        case (mode_reg)
            MODE_SET: newb = cur | bit_reg;
            MODE_XOR: newb = cur ^ bit_reg;
            default:  newb = cur & ~bit_reg;
        endcase
        xe_n = xe_reg + dx_reg;
        ye_n = ye_reg + dy_reg;
    end

    // S_GEN latches a point and steps the walker; t_reg flags done, or cx and cy for circles.
    assign gen_done = (cmd_reg.kind == KIND_LINE) ? (t_reg > dist_reg) :
                      (cmd_reg.kind == KIND_CIRCLE) ?
                          ((oct_reg == 3'd0) && ($signed({1'b0, cx_reg}) > cy_reg)) :
                          (t_reg != 9'd0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) state_next = S_START;
            S_START:
            begin
                unique case (cmd_reg.kind)
                    KIND_DOT, KIND_TOGGLE, KIND_LINE, KIND_CIRCLE: state_next = S_GEN;
                    KIND_READ:  state_next = S_RDB;
                    KIND_CLEAR: state_next = S_CLEAR;
                    default:    state_next = S_OUT;
                endcase
            end
            S_CLEAR: if (clr_last) state_next = boot_reg ? S_IDLE : S_OUT;
            S_GEN:   state_next = gen_done ? S_OUT : S_RD;
            S_RD:    state_next = S_WR;
            S_WR:    state_next = S_GEN;
            S_RDB:   state_next = S_RDB2;
            S_RDB2:  state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD || state_reg == S_RDB)
        begin
            rdata_reg <= mem[raddr];
        end
        if (state_reg == S_WR)
        begin
            mem[addr_reg] <= newb;
        end
        else if (state_reg == S_CLEAR)
        begin
            mem[clr_reg] <= 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            boot_reg  <= 1'b1;
            clr_reg   <= '0;
            obad_reg  <= 1'b0;
            obyte_reg <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                    end
                    clr_reg <= '0;
                end
                S_START:
                begin
                    obad_reg  <= cmd_reg.bad;
                    obyte_reg <= 8'd0;
                    t_reg     <= 9'd0;
                    mode_reg  <= (cmd_reg.kind == KIND_TOGGLE) ? MODE_XOR :
                                 (cmd_reg.on ? MODE_SET : MODE_CLR);
                    col_reg   <= cmd_reg.sx;
                    row_reg   <= cmd_reg.sy;
                    stx_reg   <= (cmd_reg.ex >= cmd_reg.sx) ? 8'd1 : 8'hFF;
                    sty_reg   <= (cmd_reg.ey >= cmd_reg.sy) ? 8'd1 : 8'hFF;
                    begin
                        logic [8:0] a, b;
                        a = (cmd_reg.ex >= cmd_reg.sx) ? {1'b0, cmd_reg.ex - cmd_reg.sx}
                                                       : {1'b0, cmd_reg.sx - cmd_reg.ex};
                        b = (cmd_reg.ey >= cmd_reg.sy) ? {1'b0, cmd_reg.ey - cmd_reg.sy}
                                                       : {1'b0, cmd_reg.sy - cmd_reg.ey};
                        dx_reg   <= a;
                        dy_reg   <= b;
                        xe_reg   <= a;
                        ye_reg   <= b;
                        dist_reg <= (a > b) ? a : b;
                    end
                    cx_reg  <= 8'd0;
                    cy_reg  <= signed'({1'b0, cmd_reg.r});
                    d_reg   <= 12'sd3 - 12'(signed'({3'b0, cmd_reg.r, 1'b0}));
                    oct_reg <= 3'd0;
                    // Read address of the read-byte command.
                    addr_reg <= AW'(32'(mod_by(cmd_reg.sy, RCP_P, 9'(PAGES))) * COLUMNS
                                    + 32'(mod_by(cmd_reg.sx, RCP_C, 9'(COLUMNS))));
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_last)
                    begin
                        boot_reg <= 1'b0;
                    end
                end
                S_GEN:
                begin
                    if (gen_done)
                    begin
                    end
                    else if (cmd_reg.kind == KIND_LINE)
                    begin
                        px_reg <= mod_by(col_reg, RCP_C, 9'(COLUMNS));
                        py_reg <= mod_by(row_reg, RCP_R, 9'(ROWS));
                        t_reg  <= t_reg + 9'd1;
                        if (xe_n > dist_reg)
                        begin
                            xe_reg  <= xe_n - dist_reg;
                            col_reg <= col_reg + stx_reg;
                        end
                        else
                        begin
                            xe_reg <= xe_n;
                        end
                        if (ye_n > dist_reg)
                        begin
                            ye_reg  <= ye_n - dist_reg;
                            row_reg <= row_reg + sty_reg;
                        end
                        else
                        begin
                            ye_reg <= ye_n;
                        end
                    end
                    else if (cmd_reg.kind == KIND_CIRCLE)
                    begin
                        px_reg  <= mod_by(ox, RCP_C, 9'(COLUMNS));
                        py_reg  <= mod_by(oy, RCP_R, 9'(ROWS));
                        oct_reg <= oct_reg + 3'd1;
                        if (oct_reg == 3'd7)
                        begin
                            if (d_reg < 0)
                            begin
                                d_reg <= d_reg + 12'(signed'({2'b0, cx_reg, 2'b0})) + 12'sd6;
                            end
                            else
                            begin
                                d_reg <= d_reg + 12'(signed'({2'b0, cx_reg, 2'b0}))
                                         - 12'(signed'({2'b0, cy_reg[7:0], 2'b0})) + 12'sd10;
                                cy_reg <= cy_reg - 9'sd1;
                            end
                            cx_reg <= cx_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        px_reg <= mod_by(cmd_reg.sx, RCP_C, 9'(COLUMNS));
                        py_reg <= mod_by(cmd_reg.sy, RCP_R, 9'(ROWS));
                        t_reg  <= 9'd1;
                    end
                end
                S_RD:
                begin
                    addr_reg <= waddr;
                    bit_reg  <= wbit;
                end
                S_WR: ;
                S_RDB:  ;
                S_RDB2: obyte_reg <= cur;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### sim/tb.sv
// Testbench for the monochrome framebuffer raster unit with a scoreboard predictor.
`timescale 1ns / 100ps
`default_nettype none

class raster_scoreboard;
    bit [7:0] frame [0:1023];
    bit [7:0] want_byte [$];
    bit       want_bad [$];
    int       errors;

    function new();
        foreach (frame[i]) frame[i] = 8'h00;
        errors = 0;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function void plot(bit [7:0] x, bit [7:0] y, mfb_pkg::mode_t mode);
        int col;
        int row;
        bit [9:0] idx;
        bit [7:0] mask;
        col = int'(x) % 128;
        row = int'(y) % 64;
        idx = 10'((row >> 3) * 128 + col);
        mask = 8'd1 << (row & 7);
        if (mode == mfb_pkg::MODE_XOR) frame[idx] ^= mask;
        else if (mode == mfb_pkg::MODE_SET) frame[idx] |= mask;
        else frame[idx] &= ~mask;
    endfunction

    function void draw_line(bit [7:0] sx, bit [7:0] sy, bit [7:0] ex, bit [7:0] ey,
                            mfb_pkg::mode_t mode);
        int dx;
        int dy;
        int span;
        int xerr;
        int yerr;
        bit [7:0] col;
        bit [7:0] row;
        bit [7:0] stx;
        bit [7:0] sty;
        col = sx;
        row = sy;
        if (ex >= sx) begin dx = int'(ex) - int'(sx); stx = 8'd1; end
        else begin dx = int'(sx) - int'(ex); stx = 8'hFF; end
        if (ey >= sy) begin dy = int'(ey) - int'(sy); sty = 8'd1; end
        else begin dy = int'(sy) - int'(ey); sty = 8'hFF; end
        span = (dx > dy) ? dx : dy;
        xerr = dx;
        yerr = dy;
        for (int t = 0; t <= span; t++)
        begin
            plot(col, row, mode);
            xerr += dx;
            yerr += dy;
            if (xerr > span) begin xerr -= span; col = col + stx; end
            if (yerr > span) begin yerr -= span; row = row + sty; end
        end
    endfunction

    function void draw_circle(bit [7:0] xc, bit [7:0] yc, bit [7:0] r, mfb_pkg::mode_t mode);
        int x;
        int y;
        int d;
        int cx;
        int cy;
        x = 0;
        y = int'(r);
        d = 3 - 2 * int'(r);
        cx = int'(xc);
        cy = int'(yc);
        while (x <= y)
        begin
            plot(8'(cx + x), 8'(cy + y), mode);
            plot(8'(cx - x), 8'(cy + y), mode);
            plot(8'(cx + x), 8'(cy - y), mode);
            plot(8'(cx - x), 8'(cy - y), mode);
            plot(8'(cx + y), 8'(cy + x), mode);
            plot(8'(cx - y), 8'(cy + x), mode);
            plot(8'(cx + y), 8'(cy - x), mode);
            plot(8'(cx - y), 8'(cy - x), mode);
            if (d < 0) d = d + 4 * x + 6;
            else begin d = d + 4 * (x - y) + 10; y--; end
            x++;
        end
    endfunction

    function void note_command(bit [2:0] k, bit [7:0] sx, bit [7:0] sy, bit [7:0] ex,
                               bit [7:0] ey, bit [7:0] r, bit on);
        bit [7:0] rd;
        bit bad;
        mfb_pkg::mode_t mode;
        rd = 8'h00;
        bad = 1'b0;
        mode = on ? mfb_pkg::MODE_SET : mfb_pkg::MODE_CLR;
        case (k)
            mfb_pkg::KIND_DOT:    plot(sx, sy, mode);
            mfb_pkg::KIND_TOGGLE: plot(sx, sy, mfb_pkg::MODE_XOR);
            mfb_pkg::KIND_LINE:   draw_line(sx, sy, ex, ey, mode);
            mfb_pkg::KIND_CIRCLE: draw_circle(sx, sy, r, mode);
            mfb_pkg::KIND_READ:   rd = frame[{sy[2:0], sx[6:0]}];
            mfb_pkg::KIND_CLEAR:  foreach (frame[i]) frame[i] = 8'h00;
            default:              bad = 1'b1;
        endcase
        want_byte.push_back(rd);
        want_bad.push_back(bad);
    endfunction

    task check_result(bit [7:0] rd, bit bad);
        bit [7:0] eb;
        bit ebad;
        if (want_byte.size() == 0)
        begin
            report($sformatf("unexpected result byte %h bad %b", rd, bad));
            return;
        end
        eb = want_byte.pop_front();
        ebad = want_bad.pop_front();
        if (rd !== eb)
            report($sformatf("read_byte %h, wanted %h", rd, eb));
        if (bad !== ebad)
            report($sformatf("bad_command %b, wanted %b", bad, ebad));
    endtask
endclass

module tb;
    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] kind;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic [7:0] radius;
    logic       pixel_on;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] read_byte;
    logic       bad_command;

    raster_scoreboard board;
    longint cycles;
    bit hold_off;
    int recv_mode;

    mono_framebuffer_line_circle_raster_unit uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .start_x(start_x), .start_y(start_y), .end_x(end_x),
        .end_y(end_y), .radius(radius), .pixel_on(pixel_on),
        .out_valid(out_valid), .out_stall(out_stall),
        .read_byte(read_byte), .bad_command(bad_command)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        radius = '0;
        pixel_on = 1'b0;
        cycles = 0;
        hold_off = 1'b0;
        recv_mode = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd40000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Results are checked at the edge that accepts them.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(read_byte, bad_command);
    end

    // Receiver stall process: random waits per word when recv_mode is set, or a long hold when asked.
    initial
    begin : receiver
        int wait_n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            if (recv_mode == 0) wait_n = 0;
            else wait_n = int'($urandom_range(0, 15));
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_word(input bit [2:0] k, input bit [7:0] sx, input bit [7:0] sy,
                             input bit [7:0] ex, input bit [7:0] ey, input bit [7:0] r,
                             input bit on, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        radius <= r;
        pixel_on <= on;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_command(k, sx, sy, ex, ey, r, on);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.want_byte.size() != 0) @(posedge clk);
    endtask

    // Mostly short strokes; an occasional long one reaches the coordinate extremes.
    function automatic bit [7:0] near(bit [7:0] base);
        if ($urandom_range(0, 9) == 0) return 8'($urandom);
        return 8'(base + $urandom_range(0, 24) - 12);
    endfunction

    task automatic random_word(input int gap);
        bit [2:0] k;
        bit [7:0] sx;
        bit [7:0] sy;
        bit [7:0] r;
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 25) k = mfb_pkg::KIND_DOT;
        else if (pick < 40) k = mfb_pkg::KIND_TOGGLE;
        else if (pick < 55) k = mfb_pkg::KIND_LINE;
        else if (pick < 62) k = mfb_pkg::KIND_CIRCLE;
        else if (pick < 94) k = mfb_pkg::KIND_READ;
        else if (pick < 96) k = mfb_pkg::KIND_CLEAR;
        else k = ($urandom_range(0, 1) == 0) ? mfb_pkg::KIND_RSV0 : mfb_pkg::KIND_RSV1;
        sx = 8'($urandom);
        sy = 8'($urandom);
        r = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
        send_word(k, sx, sy, near(sx), near(sy), r, 1'($urandom_range(0, 1)), gap);
    endtask

    initial
    begin : stimulus
        int gap_mode;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: extremes, every kind, wrap cases and the radius-zero circle.
        send_word(mfb_pkg::KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_DOT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 0);
        send_word(mfb_pkg::KIND_DOT, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1, 0);
        send_word(mfb_pkg::KIND_READ, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_TOGGLE, 8'd127, 8'd63, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_READ, 8'd127, 8'd7, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_DOT, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_LINE, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 1'b1, 0);
        send_word(mfb_pkg::KIND_LINE, 8'd200, 8'd10, 8'd3, 8'd60, 8'd0, 1'b1, 0);
        send_word(mfb_pkg::KIND_LINE, 8'd5, 8'd5, 8'd5, 8'd5, 8'd0, 1'b1, 0);
        send_word(mfb_pkg::KIND_READ, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_CIRCLE, 8'd2, 8'd2, 8'd0, 8'd0, 8'd0, 1'b1, 0);
        send_word(mfb_pkg::KIND_CIRCLE, 8'd64, 8'd32, 8'd0, 8'd0, 8'd10, 1'b1, 0);
        send_word(mfb_pkg::KIND_CIRCLE, 8'd1, 8'd1, 8'd0, 8'd0, 8'd255, 1'b1, 0);
        send_word(mfb_pkg::KIND_READ, 8'd64, 8'd2, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_CIRCLE, 8'd64, 8'd32, 8'd0, 8'd0, 8'd10, 1'b0, 0);
        send_word(mfb_pkg::KIND_READ, 8'd74, 8'd4, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_RSV0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 1'b1, 0);
        send_word(mfb_pkg::KIND_RSV1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 0);
        send_word(mfb_pkg::KIND_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        send_word(mfb_pkg::KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 0);
        recv_mode = 1;

        // Long receiver hold while words keep coming, so the input backs up.
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++) random_word(0);
        drain();

        // Random words in runs with and without gaps; the sender pauses midway until everything has come back.
        for (int i = 0; i < 1800; i++)
        begin
            if (i % 300 == 0) recv_mode = int'($urandom_range(0, 1));
            gap_mode = (i / 150) % 2;
            random_word(gap_mode ? int'($urandom_range(0, 15)) : 0);
            if (i == 900) drain();
        end
        drain();
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.want_byte.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
